>>> hw/rtl/i2c_master_register_access_defines.svh
// ----------------------------------------------------------------------------
// I2C master register access: assertion macros
// Concurrent check macros, empty when built for synthesis
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_REGISTER_ACCESS_DEFINES_SVH
`define I2C_MASTER_REGISTER_ACCESS_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define I2CM_ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("i2cm check failed");

// next-cycle implication
`define I2CM_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("i2cm check failed");

`else

`define I2CM_ASSERT_IMPLIES(label, clk, rst_n, cond, expr)
`define I2CM_ASSERT_NEXT(label, clk, rst_n, cond, expr)

`endif

`endif

>>> hw/rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// I2C master register access: package
// Bus phases, command and register codes, request and result types
// ----------------------------------------------------------------------------
package i2cm_pkg;

    // bus sequencer phases
    typedef enum logic [4:0] {
        PH_IDLE     = 5'd0,
        PH_ST_B     = 5'd1,
        PH_ST_C     = 5'd2,
        PH_TX_LOW   = 5'd3,
        PH_TX_DATA  = 5'd4,
        PH_TX_HIGH  = 5'd5,
        PH_ACK_LOW  = 5'd6,
        PH_ACK_REL  = 5'd7,
        PH_ACK_HIGH = 5'd8,
        PH_ACK_HOLD = 5'd9,
        PH_ACK_END  = 5'd10,
        PH_RX_LOW   = 5'd11,
        PH_RX_HIGH  = 5'd12,
        PH_NK_LOW   = 5'd13,
        PH_NK_HIGH  = 5'd14,
        PH_NK_END   = 5'd15,
        PH_SP_A     = 5'd16,
        PH_SP_B     = 5'd17,
        PH_SP_C     = 5'd18,
        PH_WAIT     = 5'd19
    } phase_t;

    // command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_PHASE_TICKS      = 2'd0;
    localparam logic [1:0] REG_SETTLE_TICKS     = 2'd1;
    localparam logic [1:0] REG_WRITE_WAIT_TICKS = 2'd2;

    localparam int CFG_DATA_W = 24;
    localparam int TICK_W     = 24;

    // configuration reset values
    localparam logic [15:0] PHASE_TICKS_RST      = 16'd500;
    localparam logic [15:0] SETTLE_TICKS_RST     = 16'd200;
    localparam logic [23:0] WRITE_WAIT_TICKS_RST = 24'd500000;

    // one tick request
    typedef struct packed {
        logic [1:0] command;
        logic [6:0] slave_address;
        logic [7:0] register_address;
        logic [7:0] write_data;
        logic       sda_in;
    } req_t;

    // one tick result
    typedef struct packed {
        logic       scl_level;
        logic       sda_drive_low;
        logic       busy_res;
        logic       done_res;
        logic       success;
        logic [7:0] read_data;
    } res_t;

    // length of a phase in ticks
    function automatic logic [TICK_W-1:0] wait_for(
        input phase_t      ph,
        input logic [15:0] settle,
        input logic [15:0] phase,
        input logic [23:0] write_wait
    );
        logic [TICK_W-1:0] s;
        logic [TICK_W-1:0] p;
        logic [TICK_W-1:0] w;
        s = {8'd0, settle};
        p = {8'd0, phase};
        w = write_wait;
        unique case (ph)
            PH_ST_B, PH_ACK_LOW, PH_ACK_HOLD, PH_SP_A: wait_for = s;
            PH_TX_DATA:                                wait_for = s + s;
            PH_ACK_REL:                                wait_for = p;
            PH_WAIT:                                   wait_for = w;
            default:                                   wait_for = s + p;
        endcase
    endfunction

endpackage

>>> hw/rtl/i2cm_if.sv
// ----------------------------------------------------------------------------
// I2C master register access: channel interfaces
// Valid/ready channels for tick requests and tick results
// ----------------------------------------------------------------------------
interface i2cm_req_if;
    import i2cm_pkg::*;

    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface i2cm_res_if;
    import i2cm_pkg::*;

    logic valid;
    logic ready;
    res_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> hw/rtl/i2c_master_register_access.sv
// ----------------------------------------------------------------------------
// I2C master register access
// Tick-stepped I2C master doing one register write or one register read
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  ---------+-----------+-----------------------------------------------
//  req      | sink      | command, addresses, write byte, sampled SDA
//  res      | source    | SCL/SDA drive, busy, done, success, read byte
//  cfg      | write     | phase, settle and write wait tick counts
//
//  one request per cycle while results drain: each request is one bus
//  tick, and the sequencer state and result register update as it is taken
//  the result register holds a finished result while the next request
//  is taken whenever the result is drained in the same cycle
//  reset returns to idle with the default tick counts and no pending result
// ----------------------------------------------------------------------------
`include "i2c_master_register_access_defines.svh"

module i2c_master_register_access (
    input  logic                           clk,
    input  logic                           rst_n,
    i2cm_req_if.sink                       req,
    i2cm_res_if.source                     res,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [i2cm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import i2cm_pkg::*;

    // configuration
    logic [15:0] phase_ticks_reg;
    logic [15:0] settle_ticks_reg;
    logic [23:0] write_wait_ticks_reg;

    // sequencer state
    phase_t            phase_reg, phase_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [3:0]        bit_reg, bit_next;
    logic [1:0]        byte_reg, byte_next;
    logic [7:0]        shift_reg, shift_next;
    logic [6:0]        slave_reg, slave_next;
    logic [7:0]        regaddr_reg, regaddr_next;
    logic [7:0]        wdata_reg, wdata_next;
    logic              is_read_reg, is_read_next;
    logic              ok_reg, ok_next;
    logic [7:0]        last_reg, last_next;
    logic              enter_en;
    logic              done;

    // result register
    logic res_valid_reg;
    res_t res_reg, res_next;
    logic accept;

    assign req.ready   = !res_valid_reg || res.ready;
    assign accept      = req.valid && req.ready;
    assign res.valid   = res_valid_reg;
    assign res.payload = res_reg;

    // byte sent at a given position of the transfer
    function automatic logic [7:0] byte_for(
        input logic [1:0] idx,
        input logic [6:0] slave,
        input logic [7:0] regaddr,
        input logic [7:0] wdata,
        input logic       rd
    );
        priority if (idx == 2'd0)
            byte_for = {slave, 1'b0};
        else if (idx == 2'd1)
            byte_for = regaddr;
        else if (rd)
            byte_for = {slave, 1'b1};
        else
            byte_for = wdata;
    endfunction

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg      <= PHASE_TICKS_RST;
            settle_ticks_reg     <= SETTLE_TICKS_RST;
            write_wait_ticks_reg <= WRITE_WAIT_TICKS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PHASE_TICKS:      phase_ticks_reg      <= cfg_data[15:0];
                REG_SETTLE_TICKS:     settle_ticks_reg     <= cfg_data[15:0];
                REG_WRITE_WAIT_TICKS: write_wait_ticks_reg <= cfg_data[23:0];
                default:              ;
            endcase
        end
    end

    // sequencer next state
    always_comb
    begin
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        bit_next     = bit_reg;
        byte_next    = byte_reg;
        shift_next   = shift_reg;
        slave_next   = slave_reg;
        regaddr_next = regaddr_reg;
        wdata_next   = wdata_reg;
        is_read_next = is_read_reg;
        ok_next      = ok_reg;
        last_next    = last_reg;
        enter_en     = 1'b0;
        done         = 1'b0;

        if (phase_reg == PH_IDLE)
        begin
            if (req.payload.command == CMD_WRITE || req.payload.command == CMD_READ)
            begin
                slave_next   = req.payload.slave_address;
                regaddr_next = req.payload.register_address;
                wdata_next   = req.payload.write_data;
                is_read_next = (req.payload.command == CMD_READ);
                ok_next      = 1'b1;
                byte_next    = 2'd0;
                bit_next     = 4'd0;
                shift_next   = {req.payload.slave_address, 1'b0};
                phase_next   = PH_ST_B;
                enter_en     = 1'b1;
            end
        end
        else if (tick_reg > 24'd1)
        begin
            tick_next = tick_reg - 24'd1;
        end
        else
        begin
            enter_en = 1'b1;
            unique case (phase_reg)
                PH_ST_B: phase_next = PH_ST_C;
                PH_ST_C:
                begin
                    bit_next   = 4'd0;
                    phase_next = PH_TX_LOW;
                end
                PH_TX_LOW:  phase_next = PH_TX_DATA;
                PH_TX_DATA: phase_next = PH_TX_HIGH;
                PH_TX_HIGH:
                begin
                    bit_next   = bit_reg + 4'd1;
                    phase_next = (bit_next >= 4'd8) ? PH_ACK_LOW : PH_TX_LOW;
                end
                PH_ACK_LOW: phase_next = PH_ACK_REL;
                PH_ACK_REL: phase_next = PH_ACK_HIGH;
                PH_ACK_HIGH:
                begin
                    // slave NACK clears success
                    if (req.payload.sda_in)
                        ok_next = 1'b0;
                    phase_next = PH_ACK_HOLD;
                end
                PH_ACK_HOLD: phase_next = PH_ACK_END;
                PH_ACK_END:
                begin
                    priority if (!ok_reg)
                        phase_next = PH_SP_A;
                    else if (byte_reg >= 2'd2)
                    begin
                        if (is_read_reg)
                        begin
                            bit_next   = 4'd0;
                            shift_next = 8'd0;
                            phase_next = PH_RX_LOW;
                        end
                        else
                            phase_next = PH_SP_A;
                    end
                    else
                    begin
                        byte_next  = byte_reg + 2'd1;
                        shift_next = byte_for(byte_next, slave_reg, regaddr_reg,
                                              wdata_reg, is_read_reg);
                        bit_next   = 4'd0;
                        phase_next = (is_read_reg && byte_next == 2'd2) ? PH_ST_B
                                                                       : PH_TX_LOW;
                    end
                end
                PH_RX_LOW: phase_next = PH_RX_HIGH;
                PH_RX_HIGH:
                begin
                    shift_next = {shift_reg[6:0], req.payload.sda_in};
                    bit_next   = bit_reg + 4'd1;
                    phase_next = (bit_next >= 4'd8) ? PH_NK_LOW : PH_RX_LOW;
                end
                PH_NK_LOW:  phase_next = PH_NK_HIGH;
                PH_NK_HIGH: phase_next = PH_NK_END;
                PH_NK_END:
                begin
                    last_next  = shift_reg;
                    phase_next = PH_SP_A;
                end
                PH_SP_A: phase_next = PH_SP_B;
                PH_SP_B: phase_next = PH_SP_C;
                PH_SP_C:
                begin
                    if (!is_read_reg && ok_reg)
                        phase_next = PH_WAIT;
                    else
                    begin
                        enter_en   = 1'b0;
                        phase_next = PH_IDLE;
                        tick_next  = '0;
                        done       = 1'b1;
                    end
                end
                PH_WAIT:
                begin
                    enter_en   = 1'b0;
                    phase_next = PH_IDLE;
                    tick_next  = '0;
                    done       = 1'b1;
                end
                default:
                begin
                    // unused phase codes fall back to idle
                    enter_en   = 1'b0;
                    phase_next = PH_IDLE;
                    tick_next  = '0;
                end
            endcase
        end

        // load the length of a newly entered phase
        if (enter_en)
            tick_next = wait_for(phase_next, settle_ticks_reg, phase_ticks_reg,
                                 write_wait_ticks_reg);
    end

    // pin levels and result fields from the updated state
    always_comb
    begin
        logic [2:0] pos;
        pos = 3'd0;
        res_next.scl_level     = 1'b1;
        res_next.sda_drive_low = 1'b0;
        unique case (phase_next)
            PH_ST_C, PH_SP_B: res_next.sda_drive_low = 1'b1;
            PH_TX_LOW:
            begin
                res_next.scl_level = 1'b0;
                if (bit_next == 4'd0)
                    res_next.sda_drive_low = (byte_next == 2'd0) ||
                                             (is_read_next && byte_next == 2'd2);
                else
                begin
                    pos = 3'd7 - (bit_next[2:0] - 3'd1);
                    res_next.sda_drive_low = !shift_next[pos];
                end
            end
            PH_TX_DATA:
            begin
                res_next.scl_level     = 1'b0;
                pos                    = 3'd7 - bit_next[2:0];
                res_next.sda_drive_low = !shift_next[pos];
            end
            PH_TX_HIGH:
            begin
                pos                    = 3'd7 - bit_next[2:0];
                res_next.sda_drive_low = !shift_next[pos];
            end
            PH_ACK_LOW:
            begin
                res_next.scl_level     = 1'b0;
                res_next.sda_drive_low = !shift_next[0];
            end
            PH_ACK_REL, PH_ACK_END, PH_RX_LOW, PH_NK_LOW, PH_NK_END:
                res_next.scl_level = 1'b0;
            PH_SP_A:
            begin
                res_next.scl_level     = 1'b0;
                res_next.sda_drive_low = 1'b1;
            end
            default: ;
        endcase
        res_next.busy_res  = (phase_next != PH_IDLE);
        res_next.done_res  = done;
        res_next.success   = done && ok_next;
        res_next.read_data = last_next;
    end

    // state update on each request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            tick_reg    <= '0;
            bit_reg     <= '0;
            byte_reg    <= '0;
            shift_reg   <= '0;
            slave_reg   <= '0;
            regaddr_reg <= '0;
            wdata_reg   <= '0;
            is_read_reg <= 1'b0;
            ok_reg      <= 1'b0;
            last_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            bit_reg     <= bit_next;
            byte_reg    <= byte_next;
            shift_reg   <= shift_next;
            slave_reg   <= slave_next;
            regaddr_reg <= regaddr_next;
            wdata_reg   <= wdata_next;
            is_read_reg <= is_read_next;
            ok_reg      <= ok_next;
            last_reg    <= last_next;
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (accept)
            res_valid_reg <= 1'b1;
        else if (res.ready)
            res_valid_reg <= 1'b0;
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res_next;
    end

    // checks
    `I2CM_ASSERT_IMPLIES(a_success_with_done, clk, rst_n,
        res_valid_reg && res_reg.success, res_reg.done_res)
    `I2CM_ASSERT_IMPLIES(a_done_not_busy, clk, rst_n,
        res_valid_reg && res_reg.done_res, !res_reg.busy_res)
    `I2CM_ASSERT_IMPLIES(a_idle_bus_released, clk, rst_n,
        res_valid_reg && !res_reg.busy_res, res_reg.scl_level && !res_reg.sda_drive_low)
    `I2CM_ASSERT_IMPLIES(a_idle_tick_clear, clk, rst_n,
        phase_reg == PH_IDLE, tick_reg == '0)
    `I2CM_ASSERT_IMPLIES(a_counters_in_range, clk, rst_n,
        1'b1, bit_reg <= 4'd8 && byte_reg != 2'd3)
    `I2CM_ASSERT_NEXT(a_stall_holds_state, clk, rst_n,
        !accept, $stable(phase_reg) && $stable(tick_reg))

endmodule

>>> tb/tb_i2c_master_register_access.sv
// ----------------------------------------------------------------------------
// I2C master register access: testbench
// Drives bus ticks into the master, acting as the slave on SDA so that
// acknowledges and read bits land on the sampling tick, and checks every
// tick result against a cycle-accurate sequencer model kept in step here.
// Covers writes, reads, slave NACK on each byte, commands while busy,
// zero and extreme tick counts, result back-pressure and sender pauses.
// ----------------------------------------------------------------------------
module tb_i2c_master_register_access;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cm_pkg::*;

    // command 3 has no name in the package and acts as a plain tick
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    i2cm_req_if req_ch ();
    i2cm_res_if res_ch ();

    i2c_master_register_access dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always #1 clk = ~clk;

    // timing registers as the sequencer sees them
    logic [15:0] timing_phase  = PHASE_TICKS_RST;
    logic [15:0] timing_settle = SETTLE_TICKS_RST;
    logic [23:0] timing_wait   = WRITE_WAIT_TICKS_RST;

    // sequencer state of the bus model
    phase_t      bus_phase = PH_IDLE;
    logic [23:0] bus_count = '0;
    logic [3:0]  bus_bit   = '0;
    logic [1:0]  bus_byte  = '0;
    logic [7:0]  bus_shift = '0;
    logic [6:0]  held_slave = '0;
    logic [7:0]  held_reg   = '0;
    logic [7:0]  held_data  = '0;
    logic        rd_mode   = 1'b0;
    logic        ack_ok    = 1'b0;
    logic [7:0]  last_rd   = '0;

    res_t tick_results_due[$];
    res_t want;
    int   mismatches = 0;
    int   ticks_sent = 0;

    // handshake pacing controls
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;
    int stall_req = 0;
    int stall_left = 0;

    // ------------------------------------------------------------------
    // bus model
    // ------------------------------------------------------------------

    // length in ticks of a phase under the current timing
    function automatic logic [23:0] phase_len(input phase_t p);
        logic [23:0] s;
        logic [23:0] q;
        s = {8'd0, timing_settle};
        q = {8'd0, timing_phase};
        case (p)
            PH_ST_B, PH_ACK_LOW, PH_ACK_HOLD, PH_SP_A: return s;
            PH_TX_DATA: return s + s;
            PH_ACK_REL: return q;
            PH_WAIT: return timing_wait;
            default: return s + q;
        endcase
    endfunction

    function automatic void enter_phase(input phase_t p);
        bus_phase = p;
        bus_count = phase_len(p);
    endfunction

    // byte on the wire for each position of the frame
    function automatic logic [7:0] frame_byte(input logic [1:0] idx);
        if (idx == 2'd0)
            return {held_slave, 1'b0};
        if (idx == 2'd1)
            return held_reg;
        if (rd_mode)
            return {held_slave, 1'b1};
        return held_data;
    endfunction

    // sda pulled low for a zero data bit, msb first
    function automatic logic drives_low(input logic [3:0] pos);
        return !bus_shift[3'd7 - pos[2:0]];
    endfunction

    // one bus tick: advance the sequencer and form the tick result
    function automatic res_t predict_bus_tick(input req_t r);
        res_t o;
        logic done;
        logic scl;
        logic sdl;
        done = 1'b0;
        if (bus_phase == PH_IDLE)
        begin
            if (r.command == CMD_WRITE || r.command == CMD_READ)
            begin
                held_slave = r.slave_address;
                held_reg   = r.register_address;
                held_data  = r.write_data;
                rd_mode    = (r.command == CMD_READ);
                ack_ok     = 1'b1;
                bus_byte   = 2'd0;
                bus_bit    = 4'd0;
                bus_shift  = frame_byte(2'd0);
                enter_phase(PH_ST_B);
            end
        end
        else if (bus_count > 24'd1)
        begin
            bus_count = bus_count - 24'd1;
        end
        else
        begin
            case (bus_phase)
                PH_ST_B: enter_phase(PH_ST_C);
                PH_ST_C:
                begin
                    bus_bit = 4'd0;
                    enter_phase(PH_TX_LOW);
                end
                PH_TX_LOW: enter_phase(PH_TX_DATA);
                PH_TX_DATA: enter_phase(PH_TX_HIGH);
                PH_TX_HIGH:
                begin
                    bus_bit = bus_bit + 4'd1;
                    if (bus_bit >= 4'd8)
                        enter_phase(PH_ACK_LOW);
                    else
                        enter_phase(PH_TX_LOW);
                end
                PH_ACK_LOW: enter_phase(PH_ACK_REL);
                PH_ACK_REL: enter_phase(PH_ACK_HIGH);
                PH_ACK_HIGH:
                begin
                    if (r.sda_in)
                        ack_ok = 1'b0;
                    enter_phase(PH_ACK_HOLD);
                end
                PH_ACK_HOLD: enter_phase(PH_ACK_END);
                // next byte, repeated start, receive or stop
                PH_ACK_END:
                begin
                    if (!ack_ok)
                        enter_phase(PH_SP_A);
                    else if (bus_byte >= 2'd2)
                    begin
                        if (rd_mode)
                        begin
                            bus_bit   = 4'd0;
                            bus_shift = 8'd0;
                            enter_phase(PH_RX_LOW);
                        end
                        else
                        begin
                            enter_phase(PH_SP_A);
                        end
                    end
                    else
                    begin
                        bus_byte  = bus_byte + 2'd1;
                        bus_shift = frame_byte(bus_byte);
                        bus_bit   = 4'd0;
                        if (rd_mode && bus_byte == 2'd2)
                            enter_phase(PH_ST_B);
                        else
                            enter_phase(PH_TX_LOW);
                    end
                end
                PH_RX_LOW: enter_phase(PH_RX_HIGH);
                PH_RX_HIGH:
                begin
                    bus_shift = {bus_shift[6:0], r.sda_in};
                    bus_bit   = bus_bit + 4'd1;
                    if (bus_bit >= 4'd8)
                        enter_phase(PH_NK_LOW);
                    else
                        enter_phase(PH_RX_LOW);
                end
                PH_NK_LOW: enter_phase(PH_NK_HIGH);
                PH_NK_HIGH: enter_phase(PH_NK_END);
                PH_NK_END:
                begin
                    last_rd = bus_shift;
                    enter_phase(PH_SP_A);
                end
                PH_SP_A: enter_phase(PH_SP_B);
                PH_SP_B: enter_phase(PH_SP_C);
                PH_SP_C:
                begin
                    if (!rd_mode && ack_ok)
                        enter_phase(PH_WAIT);
                    else
                    begin
                        bus_phase = PH_IDLE;
                        bus_count = '0;
                        done      = 1'b1;
                    end
                end
                PH_WAIT:
                begin
                    bus_phase = PH_IDLE;
                    bus_count = '0;
                    done      = 1'b1;
                end
                default:
                begin
                    bus_phase = PH_IDLE;
                    bus_count = '0;
                end
            endcase
        end

        // pin levels of the phase now entered
        scl = 1'b1;
        sdl = 1'b0;
        case (bus_phase)
            PH_ST_C, PH_SP_B: sdl = 1'b1;
            PH_TX_LOW:
            begin
                scl = 1'b0;
                if (bus_bit == 4'd0)
                    sdl = (bus_byte == 2'd0) || (rd_mode && bus_byte == 2'd2);
                else
                    sdl = drives_low(bus_bit - 4'd1);
            end
            PH_TX_DATA:
            begin
                scl = 1'b0;
                sdl = drives_low(bus_bit);
            end
            PH_TX_HIGH: sdl = drives_low(bus_bit);
            PH_ACK_LOW:
            begin
                scl = 1'b0;
                sdl = drives_low(4'd7);
            end
            PH_ACK_REL, PH_ACK_END, PH_RX_LOW, PH_NK_LOW, PH_NK_END: scl = 1'b0;
            PH_SP_A:
            begin
                scl = 1'b0;
                sdl = 1'b1;
            end
            default: ;
        endcase

        o.scl_level     = scl;
        o.sda_drive_low = sdl;
        o.busy_res      = (bus_phase != PH_IDLE);
        o.done_res      = done;
        o.success       = done & ack_ok;
        o.read_data     = last_rd;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // timing writes, accepted requests and accepted results at each edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PHASE_TICKS: timing_phase = cfg_data[15:0];
                    REG_SETTLE_TICKS: timing_settle = cfg_data[15:0];
                    REG_WRITE_WAIT_TICKS: timing_wait = cfg_data[23:0];
                    default: ;
                endcase
            end
            if (req_ch.valid && req_ch.ready)
                tick_results_due.push_back(predict_bus_tick(req_ch.payload));
            if (res_ch.valid && res_ch.ready)
            begin
                if (tick_results_due.size() == 0)
                begin
                    $error("tick result with no request pending");
                    mismatches++;
                end
                else
                begin
                    want = tick_results_due.pop_front();
                    check_field("scl_level", want.scl_level, res_ch.payload.scl_level);
                    check_field("sda_drive_low", want.sda_drive_low,
                                res_ch.payload.sda_drive_low);
                    check_field("busy_res", want.busy_res, res_ch.payload.busy_res);
                    check_field("done_res", want.done_res, res_ch.payload.done_res);
                    check_field("success", want.success, res_ch.payload.success);
                    check_field("read_data", want.read_data, res_ch.payload.read_data);
                end
            end
        end
    end

    // result side: random stalls, calm stretches and long hold-offs
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_req > 0)
            begin
                stall_left = stall_req;
                stall_req  = 0;
            end
            if (stall_left > 0)
            begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (rx_calm)
                res_ch.ready <= 1'b1;
            else
                res_ch.ready <= ($urandom_range(99) >= 22);
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // offer one tick request; called and returning at a falling edge
    task automatic send_tick(input req_t r);
        if (!tx_calm && $urandom_range(99) < 22)
        begin
            req_ch.valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < 22);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= r;
        ticks_sent++;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    // stop offering until every pending result has come back
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (tick_results_due.size() != 0);
    endtask

    // write all three timing registers; sequencer idle, nothing pending
    task automatic set_timing(input logic [15:0] ph, input logic [15:0] st,
                              input logic [23:0] ww);
        repeat (3) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_PHASE_TICKS;
        cfg_data  <= {8'd0, ph};
        @(negedge clk);
        cfg_index <= REG_SETTLE_TICKS;
        cfg_data  <= {8'd0, st};
        @(negedge clk);
        cfg_index <= REG_WRITE_WAIT_TICKS;
        cfg_data  <= ww;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // idle tick with random fields that must not start anything
    task automatic send_idle_tick();
        req_t r;
        r.command          = $urandom_range(1) ? CMD_TICK : CMD_UNUSED;
        r.slave_address    = 7'($urandom_range(127));
        r.register_address = 8'($urandom_range(255));
        r.write_data       = 8'($urandom_range(255));
        r.sda_in           = 1'($urandom_range(1));
        send_tick(r);
    endtask

    // one transfer, ticked until the sequencer is idle again; the slave
    // answers each byte with ACK unless its bit in nack_at is set, and
    // returns slave_byte on a read
    task automatic run_transfer(input logic [1:0] cmd, input logic [6:0] slave,
                                input logic [7:0] regaddr, input logic [7:0] wdata,
                                input logic [2:0] nack_at, input logic [7:0] slave_byte,
                                input bit busy_noise, input bit pressure);
        req_t r;
        int n;
        r.command          = cmd;
        r.slave_address    = slave;
        r.register_address = regaddr;
        r.write_data       = wdata;
        r.sda_in           = 1'($urandom_range(1));
        send_tick(r);
        n = 0;
        while (bus_phase != PH_IDLE)
        begin
            r.command          = busy_noise ? 2'($urandom_range(3)) : CMD_TICK;
            r.slave_address    = 7'($urandom_range(127));
            r.register_address = 8'($urandom_range(255));
            r.write_data       = 8'($urandom_range(255));
            // sda matters only on the last tick of a high phase
            case (bus_phase)
                PH_ACK_HIGH: r.sda_in = nack_at[bus_byte];
                PH_RX_HIGH: r.sda_in = slave_byte[3'd7 - bus_bit[2:0]];
                default: r.sda_in = 1'($urandom_range(1));
            endcase
            if (pressure && n == 20)
                stall_req = 80;
            if (pressure && n == 45)
                wait_drained();
            send_tick(r);
            n++;
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset outputs, plain and unused commands under default timing
    task automatic test_idle_after_reset();
        req_t r;
        r = '{command: CMD_TICK, slave_address: 7'd0, register_address: 8'd0,
              write_data: 8'd0, sda_in: 1'b0};
        send_tick(r);
        r = '{command: CMD_UNUSED, slave_address: 7'h7F, register_address: 8'hFF,
              write_data: 8'hFF, sda_in: 1'b1};
        send_tick(r);
        r.command = CMD_TICK;
        send_tick(r);
        r = '{command: CMD_UNUSED, slave_address: 7'd0, register_address: 8'd0,
              write_data: 8'd0, sda_in: 1'b0};
        send_tick(r);
        wait_drained();
    endtask

    // largest counts only while idle, then zero counts for an aborted write
    task automatic test_timing_extremes();
        set_timing(16'hFFFF, 16'hFFFF, 24'hFFFFFF);
        repeat (3) send_idle_tick();
        wait_drained();
        set_timing(16'd0, 16'd0, 24'd0);
        run_transfer(CMD_WRITE, 7'h7F, 8'hFF, 8'hFF, 3'b001, 8'h00, 1'b0, 1'b0);
        wait_drained();
    endtask

    // register write acknowledged on every byte, no idling on either side
    task automatic test_register_write();
        set_timing(16'd1, 16'd0, 24'd2);
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        run_transfer(CMD_WRITE, 7'h55, 8'hA5, 8'h3C, 3'b000, 8'h00, 1'b0, 1'b0);
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        wait_drained();
    endtask

    // register read with repeated start; write wait at its largest
    task automatic test_register_read();
        set_timing(16'd0, 16'd0, 24'hFFFFFF);
        run_transfer(CMD_READ, 7'h2A, 8'h5A, 8'h00, 3'b000, 8'hC3, 1'b0, 1'b0);
        wait_drained();
    endtask

    // slave nack aborts to stop; a failed read keeps old data
    task automatic test_nack_abort();
        set_timing(16'd2, 16'd1, 24'hFFFFFF);
        run_transfer(CMD_WRITE, 7'h12, 8'h34, 8'h56, 3'b001, 8'h00, 1'b0, 1'b0);
        wait_drained();
        set_timing(16'd0, 16'd0, 24'hFFFFFF);
        run_transfer(CMD_READ, 7'h21, 8'h43, 8'h00, 3'b100, 8'h0F, 1'b0, 1'b0);
        wait_drained();
    endtask

    // write and read commands arriving mid-transfer are ignored
    task automatic test_busy_commands();
        set_timing(16'd0, 16'd0, 24'd2);
        run_transfer(CMD_WRITE, 7'h3C, 8'h99, 8'h66, 3'b001, 8'h00, 1'b1, 1'b0);
        wait_drained();
    endtask

    // long result hold-off that stalls requests, and a sender pause
    task automatic test_backpressure();
        set_timing(16'd0, 16'd0, 24'd3);
        run_transfer(CMD_READ, 7'h6B, 8'h0C, 8'h00, 3'b010, 8'h5B, 1'b0, 1'b1);
        wait_drained();
    endtask

    // random transfers with random timing, slave faults and idle noise
    task automatic test_random_transfers();
        int first_tick;
        logic [1:0] cmd;
        logic [2:0] nack_at;
        logic [23:0] ww;
        first_tick = ticks_sent;
        ww = 24'($urandom_range(3));
        set_timing(16'($urandom_range(1)), 16'($urandom_range(1)), ww);
        while (ticks_sent - first_tick < 80)
        begin
            repeat ($urandom_range(4)) send_idle_tick();
            if ($urandom_range(9) == 0)
                cmd = 2'($urandom_range(3));
            else
                cmd = $urandom_range(1) ? CMD_WRITE : CMD_READ;
            nack_at = ($urandom_range(4) == 0) ? 3'($urandom_range(1, 7)) : 3'b000;
            run_transfer(cmd, 7'($urandom_range(127)), 8'($urandom_range(255)),
                         8'($urandom_range(255)), nack_at, 8'($urandom_range(255)),
                         1'($urandom_range(1)), 1'b0);
        end
        wait_drained();
    endtask

    // run limit
    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // main sequence
    initial
    begin
        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        cfg_we         = 1'b0;
        cfg_index      = REG_PHASE_TICKS;
        cfg_data       = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_idle_after_reset();
        test_timing_extremes();
        test_register_write();
        test_register_read();
        test_nack_abort();
        test_busy_commands();
        test_backpressure();
        test_random_transfers();

        wait_drained();
        repeat (8) @(posedge clk);
        if (tick_results_due.size() != 0)
        begin
            $error("%0d tick results never arrived", tick_results_due.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/i2cm_pkg.sv
hw/rtl/i2cm_if.sv
hw/rtl/i2c_master_register_access.sv
tb/tb_i2c_master_register_access.sv
